// ===== hw/rtl/console_float_div_sqrt_unit_core_defines.svh =====
// Assertion macros shared by the divide/square-root unit RTL.
// Depends on nothing; define NO_ASSERTIONS to compile the checks away.
`ifndef CONSOLE_FLOAT_DIV_SQRT_UNIT_CORE_DEFINES_SVH
`define CONSOLE_FLOAT_DIV_SQRT_UNIT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is low.
`define CFDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication, disabled while reset is low.
`define CFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define CFDS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/cfds_pkg.sv =====
// Types, codes and SRT step functions for the console float divide/sqrt unit.
// Depends on nothing.
`default_nettype none
package cfds_pkg;

    typedef enum logic [1:0] {
        CMD_DIV  = 2'd0,
        CMD_SQRT = 2'd1,
        CMD_RDIV = 2'd2
    } t_cmd;

    typedef logic signed [1:0] t_digit;

    localparam t_digit DIG_POS  = 2'sb01;
    localparam t_digit DIG_ZERO = 2'sb00;
    localparam t_digit DIG_NEG  = 2'sb11;

    localparam logic [30:0] FMAX_BODY = 31'h7FFF_FFFF;
    localparam logic [31:0] LOW_MASK  = 32'h00FF_FFFF;

    typedef struct packed {
        logic [31:0] sum;
        logic [31:0] carry;
        t_digit      d;
    } t_step;

    // Digit selection from an estimate of the top bits of the carry-save remainder.
    function automatic t_digit pick_digit(input logic [31:0] sum, input logic [31:0] carry);
        logic [31:0] t;
        t = ((sum & ~LOW_MASK) + carry) | (sum & LOW_MASK);
        if (!t[31] && t >= 32'h0080_0000) begin
            return DIG_POS;
        end else if (t[31] && t < 32'hFF00_0000) begin
            return DIG_NEG;
        end
        return DIG_ZERO;
    endfunction

    // One carry-save recurrence step; the next digit comes from the new remainder.
    function automatic t_step srt_step(input logic [31:0] sum, input logic [31:0] carry,
                                       input logic [31:0] sub, input t_digit d,
                                       input logic shift);
        logic [31:0] c2, add, u, c, s;
        t_step r;
        c2  = (d == DIG_POS) ? carry + 32'd1 : carry;
        add = (d == DIG_POS) ? ~sub : ((d == DIG_NEG) ? sub : 32'd0);
        u   = sum ^ c2;
        c   = ((sum & c2) | (u & add)) << 1;
        s   = u ^ add;
        r.d = (d != DIG_ZERO) ? pick_digit(s, c) : pick_digit(sum, c2);
        r.sum   = shift ? (s << 1) : s;
        r.carry = shift ? (c << 1) : c;
        return r;
    endfunction

    // Signed power of two weighted by a digit.
    function automatic logic [31:0] signed_pow(input t_digit d, input logic [4:0] sh);
        logic [31:0] p;
        p = 32'd1 << sh;
        if (d == DIG_POS) begin
            return p;
        end else if (d == DIG_NEG) begin
            return 32'd0 - p;
        end
        return 32'd0;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/console_float_div_sqrt_unit_core.sv =====
// Top level of the console float divide / square-root unit: a fully unrolled SRT pipeline.
// Depends on cfds_pkg and console_float_div_sqrt_unit_core_defines.svh.
//
//  Channel   | Ports                                    | Handshake
//  ----------+------------------------------------------+-------------------------------
//  command   | i_command, i_operand_a, i_operand_b      | start high while busy low
//  result    | o_result_raw, o_divide_by_zero,          | o_valid high for one cycle,
//            | o_invalid, o_overflow, o_underflow       | taken at the edge ending it
//
// The accepting edge loads the input register. The 51 registers are the input register,
// 24 square-root digit stages, a divider set-up register with 24 digit stages behind it,
// and one finishing stage that normalizes and applies the special cases.
// A new transaction is taken every cycle, so busy is always low.
// Reset is synchronous and active low; it clears only the stage valid bits.
// The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
`include "console_float_div_sqrt_unit_core_defines.svh"
module console_float_div_sqrt_unit_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_valid,
    output logic [31:0]      o_result_raw,
    output logic             o_divide_by_zero,
    output logic             o_invalid,
    output logic             o_overflow,
    output logic             o_underflow
);

    localparam int SQ_STEPS = 24;
    localparam int DV_STEPS = 24;
    localparam int LATENCY  = SQ_STEPS + DV_STEPS + 3;

    // Square-root stage contents. Every transaction walks these stages; only the
    // root and reciprocal-root commands use what they compute.
    typedef struct packed {
        cfds_pkg::t_cmd  cmd;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     sum;
        logic [31:0]     carry;
        logic [31:0]     q;
        cfds_pkg::t_digit d;
    } t_sq;

    // Divide stage contents; dvsr is b for a divide and the root otherwise.
    typedef struct packed {
        cfds_pkg::t_cmd  cmd;
        logic [31:0]     a;
        logic [31:0]     b;
        logic [31:0]     dvsr;
        logic [31:0]     bm;
        logic [31:0]     sum;
        logic [31:0]     carry;
        logic [31:0]     q;
        cfds_pkg::t_digit d;
    } t_dv;

    t_sq  r_sq     [SQ_STEPS+1];
    logic r_sq_vld [SQ_STEPS+1];
    t_dv  r_dv     [DV_STEPS+1];
    logic r_dv_vld [DV_STEPS+1];

    t_sq  n_sq0;
    t_dv  n_dv0;

    assign busy = 1'b0;

    // The radicand mantissa is pre-shifted one extra place for an even exponent
    // so that halving the biased exponent stays exact.
    always_comb begin
        n_sq0.cmd   = cfds_pkg::t_cmd'(i_command);
        n_sq0.a     = i_operand_a;
        n_sq0.b     = i_operand_b;
        n_sq0.sum   = i_operand_b[23] ? {7'd0, 1'b1, i_operand_b[22:0], 1'b0}
                                      : {6'd0, 1'b1, i_operand_b[22:0], 2'b00};
        n_sq0.carry = 32'd0;
        n_sq0.q     = 32'd0;
        n_sq0.d     = cfds_pkg::DIG_POS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= start && !busy;
        end
        r_sq[0] <= n_sq0;
    end

    // Square-root digit stages: the partial root feeds back as the subtrahend.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        localparam logic [4:0] SH_ADJ = 5'(SQ_STEPS - k);
        localparam logic [4:0] SH_Q   = 5'(SQ_STEPS + 1 - k);
        localparam logic       SHIFT  = (k < SQ_STEPS - 1);
        logic [31:0]     adj;
        cfds_pkg::t_step stp;
        t_sq             n_st;
        always_comb begin
            adj  = r_sq[k].q + cfds_pkg::signed_pow(r_sq[k].d, SH_ADJ);
            stp  = cfds_pkg::srt_step(r_sq[k].sum, r_sq[k].carry, adj, r_sq[k].d, SHIFT);
            n_st       = r_sq[k];
            n_st.q     = r_sq[k].q + cfds_pkg::signed_pow(r_sq[k].d, SH_Q);
            n_st.sum   = stp.sum;
            n_st.carry = stp.carry;
            n_st.d     = stp.d;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
            r_sq[k+1] <= n_st;
        end
    end

    // Root assembly and divider set-up.
    logic [31:0] sq_qf;
    logic [8:0]  sq_esum;
    logic [31:0] sq_root;

    always_comb begin
        sq_qf   = r_sq[SQ_STEPS].q + cfds_pkg::signed_pow(r_sq[SQ_STEPS].d, 5'd1);
        sq_esum = ({1'b0, r_sq[SQ_STEPS].b[30:23]} + 9'd127) >> 1;
        sq_root = {1'b0, sq_esum[7:0], sq_qf[24:2]};
        n_dv0.cmd  = r_sq[SQ_STEPS].cmd;
        n_dv0.a    = r_sq[SQ_STEPS].a;
        n_dv0.b    = r_sq[SQ_STEPS].b;
        n_dv0.dvsr = (r_sq[SQ_STEPS].cmd == cfds_pkg::CMD_DIV) ? r_sq[SQ_STEPS].b : sq_root;
        n_dv0.bm   = {6'd0, 1'b1, n_dv0.dvsr[22:0], 2'b00};
        n_dv0.sum  = {6'd0, 1'b1, r_sq[SQ_STEPS].a[22:0], 2'b00};
        n_dv0.carry = 32'd0;
        n_dv0.q     = 32'd0;
        n_dv0.d     = cfds_pkg::DIG_POS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else begin
            r_dv_vld[0] <= r_sq_vld[SQ_STEPS];
        end
        r_dv[0] <= n_dv0;
    end

    // Divide digit stages: the quotient shifts in one signed digit per stage.
    for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
        localparam logic SHIFT = (j < DV_STEPS - 1);
        cfds_pkg::t_step stp;
        t_dv             n_st;
        always_comb begin
            stp  = cfds_pkg::srt_step(r_dv[j].sum, r_dv[j].carry, r_dv[j].bm, r_dv[j].d,
                                      SHIFT);
            n_st       = r_dv[j];
            n_st.q     = {r_dv[j].q[30:0], 1'b0} + {{30{r_dv[j].d[1]}}, r_dv[j].d};
            n_st.sum   = stp.sum;
            n_st.carry = stp.carry;
            n_st.d     = stp.d;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
            r_dv[j+1] <= n_st;
        end
    end

    // Finishing stage: last digit, normalization, exponent range and special cases.
    t_dv                 fin;
    logic [31:0]         fin_q;
    logic [22:0]         fin_mant;
    logic signed [10:0]  cexp_pre;
    logic signed [10:0]  cexp;
    logic                sgn, az, bz;
    logic [31:0]         div_res;
    logic                div_ovf, div_unf;
    logic [31:0]         n_res;
    logic                n_dbz, n_inv, n_ovf, n_unf;
    logic                r_valid;
    logic [31:0]         r_res;
    logic                r_dbz, r_inv, r_ovf, r_unf;

    always_comb begin
        fin      = r_dv[DV_STEPS];
        fin_q    = {fin.q[30:0], 1'b0} + {{30{fin.d[1]}}, fin.d};
        sgn      = fin.a[31] ^ fin.dvsr[31];
        az       = (fin.a[30:23] == 8'd0);
        bz       = (fin.b[30:23] == 8'd0);
        cexp_pre = $signed({3'b000, fin.a[30:23]}) - $signed({3'b000, fin.dvsr[30:23]})
                   + 11'sd126;
        if (fin_q[24]) begin
            cexp     = cexp_pre + 11'sd1;
            fin_mant = fin_q[23:1];
        end else begin
            cexp     = cexp_pre;
            fin_mant = fin_q[22:0];
        end
        div_ovf = 1'b0;
        div_unf = 1'b0;
        // A zero dividend over a nonzero divisor gives a signed zero and no flag.
        if (az) begin
            div_res = {sgn, 31'd0};
        end else if (cexp_pre > 11'sd255 || cexp > 11'sd255) begin
            div_ovf = 1'b1;
            div_res = {sgn, cfds_pkg::FMAX_BODY};
        end else if (cexp_pre < 11'sd0 || cexp < 11'sd1) begin
            div_unf = 1'b1;
            div_res = {sgn, 31'd0};
        end else begin
            div_res = {sgn, cexp[7:0], fin_mant};
        end

        n_res = 32'd0;
        n_dbz = 1'b0;
        n_inv = 1'b0;
        n_ovf = 1'b0;
        n_unf = 1'b0;
        case (fin.cmd)
            cfds_pkg::CMD_DIV, cfds_pkg::CMD_RDIV: begin
                // A zero divisor (or root of zero) saturates; zero over zero is invalid.
                if (bz) begin
                    n_res = {sgn, cfds_pkg::FMAX_BODY};
                    n_inv = az;
                    n_dbz = !az;
                end else begin
                    n_res = div_res;
                    n_ovf = div_ovf;
                    n_unf = div_unf;
                end
            end
            cfds_pkg::CMD_SQRT: begin
                n_res = bz ? 32'd0 : fin.dvsr;
                n_inv = fin.b[31];
            end
            default: begin
                n_res = 32'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv_vld[DV_STEPS];
        end
        r_res <= n_res;
        r_dbz <= n_dbz;
        r_inv <= n_inv;
        r_ovf <= n_ovf;
        r_unf <= n_unf;
    end

    assign o_valid          = r_valid;
    assign o_result_raw     = r_res;
    assign o_divide_by_zero = r_dbz;
    assign o_invalid        = r_inv;
    assign o_overflow       = r_ovf;
    assign o_underflow      = r_unf;

    // Every accepted transaction comes out after the fixed pipeline latency.
    `CFDS_ASSERT_IMPLIES(a_latency, i_clk, i_rst_n, start && !busy, ##LATENCY o_valid)
    // At most one exception flag is raised per result.
    `CFDS_ASSERT_IMPLIES(a_one_flag, i_clk, i_rst_n, o_valid,
        $countones({o_divide_by_zero, o_invalid, o_overflow, o_underflow}) <= 1)
    // Overflow always saturates the magnitude.
    `CFDS_ASSERT_IMPLIES(a_ovf_sat, i_clk, i_rst_n, o_valid && o_overflow,
        o_result_raw[30:0] == cfds_pkg::FMAX_BODY)
    // Underflow always flushes the magnitude to zero.
    `CFDS_ASSERT_IMPLIES(a_unf_zero, i_clk, i_rst_n, o_valid && o_underflow,
        o_result_raw[30:0] == 31'd0)

endmodule
`default_nettype wire

// ===== test/tb_console_float_div_sqrt_unit_core.sv =====
// Testbench for the console float divide / square-root unit: directed and random transactions.
// Depends on cfds_pkg and console_float_div_sqrt_unit_core; predicts each result in place.
`default_nettype none
module tb_console_float_div_sqrt_unit_core;
    timeunit 1ns;
    timeprecision 1ps;

    // The pipeline is 51 stages deep, so drain time at the end is generous.
    localparam int PIPE_DEPTH    = 51;
    localparam int DRAIN_CYCLES  = PIPE_DEPTH + 20;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_ITEMS  = 950;

    // The one command code the unit does not define.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
    localparam logic [31:0] EXP_MASK   = 32'h7F80_0000;
    localparam logic [31:0] BODY_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] MANT_MASK  = 32'h007F_FFFF;
    localparam logic [31:0] HIDDEN_ONE = 32'h0080_0000;
    localparam logic [31:0] EST_LOW    = 32'h00FF_FFFF;

    typedef struct packed {
        logic [31:0] raw;
        logic        dbz;
        logic        inv;
        logic        ovf;
        logic        unf;
    } t_quotient;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic [31:0] o_result_raw;
    logic        o_divide_by_zero;
    logic        o_invalid;
    logic        o_overflow;
    logic        o_underflow;

    t_quotient pending_quotients[$];
    int        error_count;
    int        quiet_cycles;
    bit        sender_idles;

    console_float_div_sqrt_unit_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_command       (i_command),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .o_result_raw    (o_result_raw),
        .o_divide_by_zero(o_divide_by_zero),
        .o_invalid       (o_invalid),
        .o_overflow      (o_overflow),
        .o_underflow     (o_underflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor. The arithmetic mirrors the radix-2 SRT recurrence with a
    // carry-save remainder, written here on 32-bit vectors.
    // ------------------------------------------------------------------

    // Digit choice from the top bits; the low 24 bits of the sum are kept unsummed.
    function automatic cfds_pkg::t_digit estimate_digit(logic [31:0] s, logic [31:0] c);
        logic [31:0] t;
        t = ((s & ~EST_LOW) + c) | (s & EST_LOW);
        if (!t[31] && t >= 32'h0080_0000) return cfds_pkg::DIG_POS;
        if (t[31] && t < 32'hFF00_0000) return cfds_pkg::DIG_NEG;
        return cfds_pkg::DIG_ZERO;
    endfunction

    // One remainder update; returns the next digit, writes the new sum and carry back if shift_out.
    function automatic cfds_pkg::t_digit remainder_step(inout logic [31:0] s,
                                                        inout logic [31:0] c,
                                                        input logic [31:0] sub,
                                                        input cfds_pkg::t_digit d,
                                                        input bit shift_out);
        logic [31:0]      addend, u, nc, ns;
        cfds_pkg::t_digit nd;
        addend = (d == cfds_pkg::DIG_POS) ? ~sub : ((d == cfds_pkg::DIG_NEG) ? sub : 32'd0);
        if (d == cfds_pkg::DIG_POS) c = c + 32'd1;
        u  = s ^ c;
        nc = ((s & c) | (u & addend)) << 1;
        ns = u ^ addend;
        nd = (d != cfds_pkg::DIG_ZERO) ? estimate_digit(ns, nc) : estimate_digit(s, c);
        if (shift_out) begin
            s = ns << 1;
            c = nc << 1;
        end
        return nd;
    endfunction

    function automatic logic [31:0] accumulate(logic [31:0] q, cfds_pkg::t_digit d);
        if (d == cfds_pkg::DIG_POS) return q + 32'd1;
        if (d == cfds_pkg::DIG_NEG) return q - 32'd1;
        return q;
    endfunction

    function automatic logic [31:0] weighted_bit(cfds_pkg::t_digit d, int sh);
        logic [31:0] p;
        p = 32'd1 << sh;
        if (d == cfds_pkg::DIG_POS) return p;
        if (d == cfds_pkg::DIG_NEG) return 32'd0 - p;
        return 32'd0;
    endfunction

    function automatic logic [31:0] with_hidden(logic [31:0] x);
        return (x & MANT_MASK) | HIDDEN_ONE;
    endfunction

    function automatic logic [31:0] quotient_of(logic [31:0] a, logic [31:0] b,
                                                inout t_quotient fl);
        logic [31:0]      sgn, s, c, bm, q;
        bit               az, bz;
        int               e;
        cfds_pkg::t_digit d;
        sgn = (a ^ b) & SIGN_MASK;
        az  = (a & EXP_MASK) == 0;
        bz  = (b & EXP_MASK) == 0;
        if (az && !bz) return sgn;
        if (!az && bz) begin
            fl.dbz = 1'b1;
            return sgn | BODY_MAX;
        end
        if (az && bz) begin
            fl.inv = 1'b1;
            return sgn | BODY_MAX;
        end
        e = int'(a[30:23]) - int'(b[30:23]) + 126;
        if (e > 255) begin
            fl.ovf = 1'b1;
            return sgn | BODY_MAX;
        end
        if (e < 0) begin
            fl.unf = 1'b1;
            return sgn;
        end
        s  = with_hidden(a) << 2;
        bm = with_hidden(b) << 2;
        c  = 0;
        q  = 0;
        d  = cfds_pkg::DIG_POS;
        for (int i = 0; i < 23; i++) begin
            q = accumulate(q << 1, d);
            d = remainder_step(s, c, bm, d, 1'b1);
        end
        q = accumulate(q << 1, d);
        d = remainder_step(s, c, bm, d, 1'b0);
        q = accumulate(q << 1, d);
        if (q >= 32'h0100_0000) begin
            e++;
            q = q >> 1;
        end
        if (e > 255) begin
            fl.ovf = 1'b1;
            return sgn | BODY_MAX;
        end
        if (e < 1) begin
            fl.unf = 1'b1;
            return sgn;
        end
        return (q & MANT_MASK) | (32'(e) << 23) | sgn;
    endfunction

    function automatic logic [31:0] root_of(logic [31:0] x, inout t_quotient fl);
        logic [31:0]      s, c, q, adj, e;
        cfds_pkg::t_digit d;
        if ((x & EXP_MASK) == 0) begin
            if (x[31]) fl.inv = 1'b1;
            return 32'd0;
        end
        s = with_hidden(x) << 1;
        if (!x[23]) s = s << 1;   // even biased exponent: shift once more
        c = 0;
        q = 0;
        d = cfds_pkg::DIG_POS;
        for (int i = 0; i < 23; i++) begin
            adj = q + weighted_bit(d, 24 - i);
            q   = q + weighted_bit(d, 25 - i);
            d   = remainder_step(s, c, adj, d, 1'b1);
        end
        adj = q + weighted_bit(d, 1);
        q   = q + weighted_bit(d, 2);
        d   = remainder_step(s, c, adj, d, 1'b0);
        q   = q + weighted_bit(d, 1);
        e   = (32'(x[30:23]) + 32'd127) >> 1;
        if (x[31]) fl.inv = 1'b1;
        return ((q >> 2) & MANT_MASK) | (e << 23);
    endfunction

    function automatic t_quotient predict_quotient(logic [1:0] cmd, logic [31:0] a,
                                                   logic [31:0] b);
        t_quotient   r;
        t_quotient   scratch;
        logic [31:0] babs, sgn, rt;
        int          e;
        r       = '0;
        scratch = '0;
        case (cmd)
            cfds_pkg::CMD_DIV: begin
                r.raw = quotient_of(a, b, r);
            end
            cfds_pkg::CMD_SQRT: begin
                r.raw = root_of(b, r);
            end
            cfds_pkg::CMD_RDIV: begin
                babs = b & BODY_MAX;
                sgn  = a & SIGN_MASK;
                if ((babs & EXP_MASK) == 0) begin
                    // Dividing by the root of zero.
                    if ((a & EXP_MASK) == 0) r.inv = 1'b1;
                    else r.dbz = 1'b1;
                    r.raw = sgn | BODY_MAX;
                end else if ((a & EXP_MASK) == 0) begin
                    r.raw = sgn;
                end else begin
                    e = int'(a[30:23]) - int'((32'(b[30:23]) + 32'd127) >> 1) + 126;
                    if (e > 255) begin
                        r.ovf = 1'b1;
                        r.raw = sgn | BODY_MAX;
                    end else if (e < 0) begin
                        r.unf = 1'b1;
                        r.raw = sgn;
                    end else begin
                        rt    = root_of(babs, scratch);
                        r.raw = quotient_of(a, rt, r);
                    end
                end
            end
            default: r = '0;   // unused command value: all zero
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking and watchdog.
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_quotient want;
        if (i_rst_n && o_valid) begin
            if (pending_quotients.size() == 0) begin
                report_mismatch("unexpected result", o_result_raw, 32'd0);
            end else begin
                want = pending_quotients.pop_front();
                if (o_result_raw !== want.raw)
                    report_mismatch("result_raw", o_result_raw, want.raw);
                if (o_divide_by_zero !== want.dbz)
                    report_mismatch("divide_by_zero", 32'(o_divide_by_zero), 32'(want.dbz));
                if (o_invalid !== want.inv)
                    report_mismatch("invalid", 32'(o_invalid), 32'(want.inv));
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", 32'(o_overflow), 32'(want.ovf));
                if (o_underflow !== want.unf)
                    report_mismatch("underflow", 32'(o_underflow), 32'(want.unf));
            end
        end
    end

    // Counts cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    // Sends one transaction, with an optional random gap first. start stays high
    // across back-to-back transactions and is only lowered for a gap or to drain.
    task automatic issue_op(logic [1:0] cmd, logic [31:0] a, logic [31:0] b);
        if (sender_idles) begin
            while ($urandom_range(99) < 32) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_quotients.push_back(predict_quotient(cmd, a, b));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_quotients.size() != 0) @(posedge i_clk);
    endtask

    // Operands whose exponents sit close, so most results stay in range.
    function automatic logic [31:0] near_one_float();
        logic [31:0] x;
        x        = $urandom;
        x[30:23] = 8'($urandom_range(100, 154));
        return x;
    endfunction

    function automatic logic [31:0] shaped_float();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(9))
            0:       x[30:23] = 8'd0;
            1:       x[30:23] = 8'hFF;
            2:       x[30:23] = 8'($urandom_range(1, 3));
            3:       x[30:23] = 8'($urandom_range(250, 255));
            4, 5, 6: x[30:23] = 8'($urandom_range(100, 154));
            default: ;
        endcase
        return x;
    endfunction

    task automatic test_directed_edges();
        issue_op(cfds_pkg::CMD_DIV,  32'h3F80_0000, 32'h3F80_0000);  // one over one
        issue_op(cfds_pkg::CMD_DIV,  32'hBFFF_FFFF, 32'h3F80_0000);  // widest mantissa
        issue_op(cfds_pkg::CMD_DIV,  32'h0000_0000, 32'h4000_0000);  // zero over nonzero
        issue_op(cfds_pkg::CMD_DIV,  32'h4000_0000, 32'h8000_0000);  // nonzero over zero
        issue_op(cfds_pkg::CMD_DIV,  32'h8012_3456, 32'h0000_0001);  // zero over zero
        issue_op(cfds_pkg::CMD_DIV,  32'h7FFF_FFFF, 32'h0080_0000);  // overflow
        issue_op(cfds_pkg::CMD_DIV,  32'h0080_0000, 32'h7FFF_FFFF);  // underflow
        issue_op(cfds_pkg::CMD_DIV,  32'h3F80_0000, 32'h3FFF_FFFF);  // quotient below one
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'h4080_0000);          // root of four
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'h4000_0000);          // root of two
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'h0000_0000);          // root of zero
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'h8000_0000);          // root of negative zero
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'hC100_0000);          // root of a negative
        issue_op(cfds_pkg::CMD_SQRT, 32'h0, 32'h7FFF_FFFF);          // largest magnitude
        issue_op(cfds_pkg::CMD_RDIV, 32'h3F80_0000, 32'h4080_0000);  // one over root of four
        issue_op(cfds_pkg::CMD_RDIV, 32'h0000_0000, 32'h0000_0000);  // zero over root of zero
        issue_op(cfds_pkg::CMD_RDIV, 32'hC000_0000, 32'h8000_0000);  // nonzero, root of zero
        issue_op(cfds_pkg::CMD_RDIV, 32'h8000_0000, 32'h4000_0000);  // zero, nonzero root
        issue_op(cfds_pkg::CMD_RDIV, 32'h7F80_0000, 32'h0080_0000);  // pre-check overflow
        issue_op(cfds_pkg::CMD_RDIV, 32'h0080_0000, 32'h7F80_0000);  // pre-check underflow
        issue_op(cfds_pkg::CMD_RDIV, 32'h4000_0000, 32'hC080_0000);  // negative radicand
        issue_op(CMD_UNUSED,         32'hFFFF_FFFF, 32'hFFFF_FFFF);  // unused command value
    endtask

    // Mostly in-range operands, with a share of edge exponents and the unused command.
    task automatic test_random_mix(int count);
        logic [1:0]  cmd;
        logic [31:0] a, b;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(19) == 0) ? CMD_UNUSED : 2'($urandom_range(2));
            if ($urandom_range(3) == 0) begin
                a = $urandom;
                b = $urandom;
            end else begin
                a = shaped_float();
                b = shaped_float();
            end
            if ($urandom_range(4) == 0) b = near_one_float();
            issue_op(cmd, a, b);
        end
    endtask

    // The sender holds off until the pipeline has emptied, then goes back to back.
    task automatic test_drain_then_burst();
        wait_drained();
        sender_idles = 1'b0;
        for (int n = 0; n < 150; n++)
            issue_op(2'($urandom_range(2)), near_one_float(), near_one_float());
        sender_idles = 1'b1;
    endtask

    initial begin
        error_count  = 0;
        quiet_cycles = 0;
        sender_idles = 1'b1;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = '0;
        i_operand_a  = '0;
        i_operand_b  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_edges();
        test_random_mix(RANDOM_ITEMS / 2);
        test_drain_then_burst();
        test_random_mix(RANDOM_ITEMS / 2 - 150);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
